// File: hdl/tea_pkg.sv
// tea_pkg: shared types, constants and the half-round mixing function
// for the tea block cipher pipeline and its checker
// no dependencies
`default_nettype none

package tea_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int NUM_STAGES  = 2 * ROUND_COUNT;
   localparam int COUNT_BITS  = $clog2(NUM_STAGES + 1);

   typedef logic [31:0] word_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [1:0]  key_sel_type;

   localparam csr_index_type CSR_KEY_WORD_0     = 3'd0;
   localparam csr_index_type CSR_KEY_WORD_1     = 3'd1;
   localparam csr_index_type CSR_KEY_WORD_2     = 3'd2;
   localparam csr_index_type CSR_KEY_WORD_3     = 3'd3;
   localparam csr_index_type CSR_ROUND_CONSTANT = 3'd4;

   localparam key_sel_type KEY_SEL_0 = 2'd0;
   localparam key_sel_type KEY_SEL_1 = 2'd1;
   localparam key_sel_type KEY_SEL_2 = 2'd2;
   localparam key_sel_type KEY_SEL_3 = 2'd3;

   localparam word_type ROUND_MULT           = word_type'(ROUND_COUNT);
   localparam word_type ROUND_CONSTANT_RESET = 32'h9E37_79B9;
   localparam word_type DECRYPT_SUM_RESET    =
      word_type'(64'(ROUND_CONSTANT_RESET) * 64'(ROUND_COUNT));

   typedef struct packed {
      logic     kind;
      word_type first_half;
      word_type second_half;
   } req_payload_type;

   typedef struct packed {
      word_type out_first_half;
      word_type out_second_half;
   } rsp_payload_type;

   typedef struct packed {
      logic     kind;
      word_type a;
      word_type b;
      word_type sum;
   } stage_type;

   function automatic word_type tea_mix(word_type h, word_type sum_key);
      return (((h << 4) ^ (h >> 5)) + h) ^ sum_key;
   endfunction

endpackage

`default_nettype wire

// File: hdl/tea_block_cipher.sv
// tea_block_cipher: 64-bit XTEA block cipher, one half-round per pipeline stage
// depends on tea_pkg
`default_nettype none

// Encrypts or decrypts one 64-bit block (two 32-bit halves) per transaction
// with a 128-bit key and a programmable round constant. The datapath is a
// pipeline of two stages per round, one for each half update, so a new
// block is taken every cycle unless a result stall backs up the pipeline. A
// block passes through every stage register in turn before it shows on the
// result port, where it stays until it is taken with rsp_ready high.
// Each stage can hold its block while the result side stalls; a free stage
// anywhere in the pipeline keeps req_ready high. Key words and the round
// constant are written through the csr port (index 0 to 3 key words,
// 4 round constant, others ignored). Every stage reads them directly, so a
// write takes effect at once for every block still in the pipeline; write
// them only while no block is in flight. csr_ready is always high.
module tea_block_cipher (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tea_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output tea_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire tea_pkg::csr_index_type   csr_index,
   input  wire tea_pkg::word_type        csr_data
);
   import tea_pkg::*;

   word_type key0_ff, key1_ff, key2_ff, key3_ff;
   word_type round_constant_ff;
   word_type dec_start_ff;
   word_type dec_start_in;

   logic      valid_ff [NUM_STAGES];
   stage_type stage_ff [NUM_STAGES];
   logic      ready_w  [NUM_STAGES];

   assign csr_ready    = 1'b1;
   assign dec_start_in = csr_data * ROUND_MULT;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff           <= '0;
         key1_ff           <= '0;
         key2_ff           <= '0;
         key3_ff           <= '0;
         round_constant_ff <= ROUND_CONSTANT_RESET;
         dec_start_ff      <= DECRYPT_SUM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_WORD_0: begin
               key0_ff <= csr_data;
            end
            CSR_KEY_WORD_1: begin
               key1_ff <= csr_data;
            end
            CSR_KEY_WORD_2: begin
               key2_ff <= csr_data;
            end
            CSR_KEY_WORD_3: begin
               key3_ff <= csr_data;
            end
            CSR_ROUND_CONSTANT: begin
               round_constant_ff <= csr_data;
               dec_start_ff      <= dec_start_in;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar j = 0; j < NUM_STAGES; j++) begin : g_stage
      localparam logic IS_EVEN = ((j % 2) == 0);

      stage_type   src_w;
      stage_type   stage_in;
      logic        src_valid_w;
      logic        down_ready_w;
      logic        use_low_w;
      key_sel_type sel_w;
      word_type    h_w;
      word_type    key_w;
      word_type    mix_w;
      word_type    tgt_w;
      word_type    upd_w;

      if (j == 0) begin : g_head
         assign src_w.kind  = req_payload.kind;
         assign src_w.a     = req_payload.first_half;
         assign src_w.b     = req_payload.second_half;
         assign src_w.sum   = req_payload.kind ? dec_start_ff : '0;
         assign src_valid_w = req_valid;
      end else begin : g_body
         assign src_w       = stage_ff[j-1];
         assign src_valid_w = valid_ff[j-1];
      end

      if (j == NUM_STAGES - 1) begin : g_tail
         assign down_ready_w = rsp_ready;
      end else begin : g_mid
         assign down_ready_w = ready_w[j+1];
      end

      assign ready_w[j] = !valid_ff[j] || down_ready_w;

      // low sum bits update the first half, bits 12:11 the second half
      always_comb begin
         use_low_w = IS_EVEN ^ src_w.kind;
         sel_w     = use_low_w ? src_w.sum[1:0] : src_w.sum[12:11];
         case (sel_w)
            KEY_SEL_0: key_w = key0_ff;
            KEY_SEL_1: key_w = key1_ff;
            KEY_SEL_2: key_w = key2_ff;
            KEY_SEL_3: key_w = key3_ff;
            default:   key_w = key0_ff;
         endcase
         h_w      = use_low_w ? src_w.b : src_w.a;
         tgt_w    = use_low_w ? src_w.a : src_w.b;
         mix_w    = tea_mix(h_w, src_w.sum + key_w);
         upd_w    = src_w.kind ? (tgt_w - mix_w) : (tgt_w + mix_w);
         stage_in = src_w;
         if (use_low_w) begin
            stage_in.a = upd_w;
         end else begin
            stage_in.b = upd_w;
         end
         if (IS_EVEN) begin
            stage_in.sum = src_w.kind ? (src_w.sum - round_constant_ff)
                                      : (src_w.sum + round_constant_ff);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (ready_w[j]) begin
            valid_ff[j] <= src_valid_w;
         end
         if (ready_w[j] && src_valid_w) begin
            stage_ff[j] <= stage_in;
         end
      end
   end

   assign req_ready                   = ready_w[0];
   assign rsp_valid                   = valid_ff[NUM_STAGES-1];
   assign rsp_payload.out_first_half  = stage_ff[NUM_STAGES-1].a;
   assign rsp_payload.out_second_half = stage_ff[NUM_STAGES-1].b;

endmodule

`default_nettype wire

// File: hdl/tea_checker.sv
// tea_checker: port-level checks on the tea block cipher, bound into every tea_block_cipher instance
// depends on tea_pkg and tea_block_cipher
`default_nettype none

module tea_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire tea_pkg::req_payload_type req_payload,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire tea_pkg::rsp_payload_type rsp_payload
);
   import tea_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  in_txn;
   logic                  out_txn;

   assign in_txn  = req_valid && req_ready;
   assign out_txn = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (in_txn && !out_txn) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (out_txn && !in_txn) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a waiting request transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_payload)))
      else $error("request dropped or changed while stalled");

   // a waiting result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result dropped or changed while stalled");

   // no result without an outstanding block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("result with no block in flight");

   // a free stage means req_ready is high
   assert property (@(posedge clock) disable iff (reset)
      (count_ff < COUNT_BITS'(NUM_STAGES)) |-> req_ready)
      else $error("request refused with room in the pipeline");

endmodule

bind tea_block_cipher tea_checker u_checker (.*);

`default_nettype wire
